// File: src/bgai_pkg.sv
// shared types, constants and helpers of the battery gauge
`timescale 1ns / 1ps

package bgai_pkg;

    // block parameters
    localparam int BURST_LEN    = 10;
    localparam int WINDOW_DEPTH = 3;

    // field widths
    localparam int SAMPLE_W  = 12;
    localparam int PCT_W     = 7;
    localparam int CFG_IDX_W = 3;
    localparam int SEG_W     = 3;

    // derived widths
    localparam int CNT_W     = $clog2(BURST_LEN + 1);
    localparam int FILL_W    = $clog2(WINDOW_DEPTH + 1);
    localparam int WIN_IDX_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int SUM_W     = SAMPLE_W + CNT_W;
    localparam int WSUM_W    = SAMPLE_W + FILL_W;
    localparam int PNUM_W    = SAMPLE_W + 5;
    localparam int DIV_W0    = (SUM_W > WSUM_W) ? SUM_W : WSUM_W;
    localparam int DIV_W     = (DIV_W0 > PNUM_W) ? DIV_W0 : PNUM_W;
    localparam int DVS_W0    = (CNT_W > FILL_W) ? CNT_W : FILL_W;
    localparam int DVS_W     = (DVS_W0 > SAMPLE_W) ? DVS_W0 : SAMPLE_W;
    localparam int DCNT_W    = $clog2(DIV_W + 1);

    // breakpoints
    localparam int POINT_COUNT = 6;
    localparam logic [PCT_W-1:0] STEP_PERCENT = 7'd20;
    localparam logic [PCT_W-1:0] FULL_PERCENT = 7'd100;
    localparam logic [SAMPLE_W-1:0] POINT_RESET [POINT_COUNT] = '{
        12'd2951, 12'd3019, 12'd3037, 12'd3091, 12'd3124, 12'd3231
    };

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_POINT_ZERO   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POINT_TWENTY = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_POINT_FORTY  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_POINT_SIXTY  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_POINT_EIGHTY = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_POINT_FULL   = 3'd5;

    // divider operand select
    typedef enum logic [1:0] {
        DIV_BURST,
        DIV_WINDOW,
        DIV_PERCENT
    } t_div_sel;

    // controller states
    typedef enum logic [3:0] {
        S_ACCEPT,
        S_CHECK,
        S_MEAN_GO,
        S_MEAN_WAIT,
        S_SUM,
        S_WIN_GO,
        S_WIN_WAIT,
        S_MAP,
        S_PCT_GO,
        S_PCT_WAIT,
        S_FAIL,
        S_OUT
    } t_state;

    // controller to datapath commands
    typedef struct packed {
        logic     acc;
        logic     clr_burst;
        logic     div_start;
        t_div_sel div_sel;
        logic     latch_mean;
        logic     sum_step;
        logic     latch_wmean;
        logic     map_load;
        logic     latch_pct;
        logic     load_ok;
        logic     load_fail;
    } t_bgai_cmd;

    // datapath to controller status
    typedef struct packed {
        logic last_attempt;
        logic no_good;
        logic div_done;
        logic sum_last;
        logic map_direct;
        logic out_free;
    } t_bgai_status;

    // percent at the low end of a segment
    function automatic logic [PCT_W-1:0] seg_base(input logic [SEG_W-1:0] seg);
        logic [PCT_W-1:0] prod;
        prod = PCT_W'(seg) * STEP_PERCENT;
        return prod;
    endfunction

endpackage

// File: src/battery_gauge_average_interpolate.sv
// top level of the battery gauge: controller plus datapath
`timescale 1ns / 1ps

// Battery gauge. Each input transaction is one converter attempt (value plus
// good flag). The last attempt of a burst of BURST_LEN attempts starts
// burst-end processing, during which no input transaction is accepted: a
// failed burst only loads a failure result; otherwise the block runs up to
// three divisions on one shared radix-2 divider (17-bit dividend at the
// default sizes) and walks the filled window entries one per cycle. One
// result transaction is produced per burst and waits in an output register;
// the burst-end step that loads it stalls only if the previous result has
// not been taken. Breakpoint registers must be written on the configuration
// port only while the block is idle; the block does not enforce this.
module battery_gauge_average_interpolate (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic [bgai_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [bgai_pkg::SAMPLE_W-1:0]     i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [bgai_pkg::SAMPLE_W-1:0]     i_sample_value,
    input  logic                              i_sample_good,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic                              o_status,
    output logic [bgai_pkg::SAMPLE_W-1:0]     o_burst_mean,
    output logic [bgai_pkg::SAMPLE_W-1:0]     o_window_mean,
    output logic [bgai_pkg::PCT_W-1:0]        o_charge_pct
);

    bgai_pkg::t_bgai_cmd    cmd;
    bgai_pkg::t_bgai_status status;

    // sequencer
    bgai_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // datapath
    bgai_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_sample_value  (i_sample_value),
        .i_sample_good   (i_sample_good),
        .i_out_ready     (i_out_ready),
        .i_cmd           (cmd),
        .o_status        (status),
        .o_out_valid     (o_out_valid),
        .o_out_status    (o_status),
        .o_burst_mean    (o_burst_mean),
        .o_window_mean   (o_window_mean),
        .o_charge_pct    (o_charge_pct)
    );

endmodule

// File: src/bgai_divider.sv
// shared radix-2 restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module bgai_divider (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [bgai_pkg::DIV_W-1:0]    i_dividend,
    input  logic [bgai_pkg::DVS_W-1:0]    i_divisor,
    output logic                          o_done,
    output logic [bgai_pkg::DIV_W-1:0]    o_quotient
);

    logic                           r_busy, n_busy;
    logic                           r_done, n_done;
    logic [bgai_pkg::DCNT_W-1:0]    r_cnt, n_cnt;
    logic [bgai_pkg::DIV_W-1:0]     r_quo, n_quo;
    logic [bgai_pkg::DVS_W-1:0]     r_rem, n_rem;
    logic [bgai_pkg::DVS_W-1:0]     r_dvs, n_dvs;
    logic [bgai_pkg::DVS_W:0]       shifted;
    logic [bgai_pkg::DVS_W:0]       diff;

    // one shift and trial subtract per cycle
    always_comb begin
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_cnt   = r_cnt;
        n_quo   = r_quo;
        n_rem   = r_rem;
        n_dvs   = r_dvs;
        shifted = {r_rem, r_quo[bgai_pkg::DIV_W-1]};
        diff    = shifted - {1'b0, r_dvs};
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = bgai_pkg::DCNT_W'(bgai_pkg::DIV_W);
            n_quo  = i_dividend;
            n_rem  = '0;
            n_dvs  = i_divisor;
        end else if (r_busy) begin
            if (shifted >= {1'b0, r_dvs}) begin
                n_rem = diff[bgai_pkg::DVS_W-1:0];
                n_quo = {r_quo[bgai_pkg::DIV_W-2:0], 1'b1};
            end else begin
                n_rem = shifted[bgai_pkg::DVS_W-1:0];
                n_quo = {r_quo[bgai_pkg::DIV_W-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == bgai_pkg::DCNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    // operand registers
    always_ff @(posedge i_clk) begin
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_dvs <= n_dvs;
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// File: src/bgai_dp.sv
// datapath: burst accumulation, window ring, breakpoint map, output register
`timescale 1ns / 1ps

module bgai_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic [bgai_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [bgai_pkg::SAMPLE_W-1:0]     i_cfg_data,
    input  logic [bgai_pkg::SAMPLE_W-1:0]     i_sample_value,
    input  logic                              i_sample_good,
    input  logic                              i_out_ready,
    input  bgai_pkg::t_bgai_cmd               i_cmd,
    output bgai_pkg::t_bgai_status            o_status,
    output logic                              o_out_valid,
    output logic                              o_out_status,
    output logic [bgai_pkg::SAMPLE_W-1:0]     o_burst_mean,
    output logic [bgai_pkg::SAMPLE_W-1:0]     o_window_mean,
    output logic [bgai_pkg::PCT_W-1:0]        o_charge_pct
);

    logic [bgai_pkg::SAMPLE_W-1:0]      r_point [bgai_pkg::POINT_COUNT];
    logic [bgai_pkg::SUM_W-1:0]         r_sum;
    logic [bgai_pkg::CNT_W-1:0]         r_good;
    logic [bgai_pkg::CNT_W-1:0]         r_attempts;
    logic [bgai_pkg::SAMPLE_W-1:0]      r_win [bgai_pkg::WINDOW_DEPTH];
    logic [bgai_pkg::WIN_IDX_W-1:0]     r_next;
    logic [bgai_pkg::FILL_W-1:0]        r_filled;
    logic [bgai_pkg::WIN_IDX_W-1:0]     r_sidx;
    logic [bgai_pkg::WSUM_W-1:0]        r_wsum;
    logic [bgai_pkg::SAMPLE_W-1:0]      r_bmean;
    logic [bgai_pkg::SAMPLE_W-1:0]      r_wmean;
    logic [bgai_pkg::PCT_W-1:0]         r_level;
    logic [bgai_pkg::PCT_W-1:0]         r_base;
    logic [bgai_pkg::PNUM_W-1:0]        r_num;
    logic [bgai_pkg::SAMPLE_W-1:0]      r_den;
    logic                               r_out_valid;
    logic                               r_out_status;
    logic [bgai_pkg::SAMPLE_W-1:0]      r_out_bmean;
    logic [bgai_pkg::SAMPLE_W-1:0]      r_out_wmean;
    logic [bgai_pkg::PCT_W-1:0]         r_out_level;

    logic                               div_done;
    logic [bgai_pkg::DIV_W-1:0]         div_quo;
    logic [bgai_pkg::DIV_W-1:0]         div_dividend;
    logic [bgai_pkg::DVS_W-1:0]         div_divisor;

    logic                               map_direct;
    logic [bgai_pkg::PCT_W-1:0]         map_pct;
    logic [bgai_pkg::SEG_W-1:0]         map_seg;
    logic [bgai_pkg::SAMPLE_W-1:0]      map_lo;
    logic [bgai_pkg::SAMPLE_W-1:0]      map_hi;
    logic [bgai_pkg::SAMPLE_W-1:0]      map_off;
    logic [bgai_pkg::PNUM_W-1:0]        map_num;
    logic                               out_free;

    // breakpoint registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < bgai_pkg::POINT_COUNT; k++) begin
                r_point[k] <= bgai_pkg::POINT_RESET[k];
            end
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                bgai_pkg::REG_POINT_ZERO:   r_point[0] <= i_cfg_data;
                bgai_pkg::REG_POINT_TWENTY: r_point[1] <= i_cfg_data;
                bgai_pkg::REG_POINT_FORTY:  r_point[2] <= i_cfg_data;
                bgai_pkg::REG_POINT_SIXTY:  r_point[3] <= i_cfg_data;
                bgai_pkg::REG_POINT_EIGHTY: r_point[4] <= i_cfg_data;
                bgai_pkg::REG_POINT_FULL:   r_point[5] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // burst accumulator
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clr_burst) begin
            r_sum      <= '0;
            r_good     <= '0;
            r_attempts <= '0;
        end else if (i_cmd.acc) begin
            if (i_sample_good) begin
                r_sum  <= r_sum + bgai_pkg::SUM_W'(i_sample_value);
                r_good <= r_good + 1'b1;
            end
            r_attempts <= r_attempts + 1'b1;
        end
    end

    // divider operand select
    always_comb begin
        case (i_cmd.div_sel)
            bgai_pkg::DIV_BURST: begin
                div_dividend = bgai_pkg::DIV_W'(r_sum);
                div_divisor  = bgai_pkg::DVS_W'(r_good);
            end
            bgai_pkg::DIV_WINDOW: begin
                div_dividend = bgai_pkg::DIV_W'(r_wsum);
                div_divisor  = bgai_pkg::DVS_W'(r_filled);
            end
            bgai_pkg::DIV_PERCENT: begin
                div_dividend = bgai_pkg::DIV_W'(r_num);
                div_divisor  = bgai_pkg::DVS_W'(r_den);
            end
            default: begin
                div_dividend = '0;
                div_divisor  = '0;
            end
        endcase
    end

    bgai_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    // window ring pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next   <= '0;
            r_filled <= '0;
        end else if (i_cmd.latch_mean) begin
            if (r_next == bgai_pkg::WIN_IDX_W'(bgai_pkg::WINDOW_DEPTH - 1)) begin
                r_next <= '0;
            end else begin
                r_next <= r_next + 1'b1;
            end
            if (r_filled != bgai_pkg::FILL_W'(bgai_pkg::WINDOW_DEPTH)) begin
                r_filled <= r_filled + 1'b1;
            end
        end
    end

    // window entries, burst mean and window sum walk
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_mean) begin
            r_win[r_next] <= div_quo[bgai_pkg::SAMPLE_W-1:0];
            r_bmean       <= div_quo[bgai_pkg::SAMPLE_W-1:0];
            r_sidx        <= '0;
            r_wsum        <= '0;
        end else if (i_cmd.sum_step) begin
            r_wsum <= r_wsum + bgai_pkg::WSUM_W'(r_win[r_sidx]);
            r_sidx <= r_sidx + 1'b1;
        end
        if (i_cmd.latch_wmean) begin
            r_wmean <= div_quo[bgai_pkg::SAMPLE_W-1:0];
        end
    end

    // segment search over the breakpoints
    always_comb begin
        logic found;
        found      = 1'b0;
        map_direct = 1'b0;
        map_pct    = '0;
        map_seg    = '0;
        map_lo     = r_point[0];
        map_hi     = r_point[1];
        if (r_wmean < r_point[0]) begin
            map_direct = 1'b1;
            map_pct    = '0;
        end else if (r_wmean >= r_point[bgai_pkg::POINT_COUNT-1]) begin
            map_direct = 1'b1;
            map_pct    = bgai_pkg::FULL_PERCENT;
        end else begin
            for (int k = 0; k < bgai_pkg::POINT_COUNT - 1; k++) begin
                if (!found && r_wmean >= r_point[k] && r_wmean < r_point[k+1]) begin
                    found   = 1'b1;
                    map_seg = bgai_pkg::SEG_W'(k);
                    map_lo  = r_point[k];
                    map_hi  = r_point[k+1];
                end
            end
            if (!found) begin
                map_direct = 1'b1;
                map_pct    = bgai_pkg::FULL_PERCENT;
            end
        end
        map_off = r_wmean - map_lo;
        // times twenty as two shifted adds
        map_num = {1'b0, map_off, 4'b0000} + {3'b000, map_off, 2'b00};
    end

    // interpolation operands and level
    always_ff @(posedge i_clk) begin
        if (i_cmd.map_load) begin
            r_num   <= map_num;
            r_den   <= map_hi - map_lo;
            r_base  <= bgai_pkg::seg_base(map_seg);
            r_level <= map_pct;
        end else if (i_cmd.latch_pct) begin
            r_level <= r_base + bgai_pkg::PCT_W'(div_quo[4:0]);
        end
    end

    assign out_free = !r_out_valid || i_out_ready;

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_ok || i_cmd.load_fail) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_ok) begin
            r_out_status <= 1'b0;
            r_out_bmean  <= r_bmean;
            r_out_wmean  <= r_wmean;
            r_out_level  <= r_level;
        end else if (i_cmd.load_fail) begin
            r_out_status <= 1'b1;
            r_out_bmean  <= '0;
            r_out_wmean  <= '0;
            r_out_level  <= '0;
        end
    end

    // status to the controller
    always_comb begin
        o_status.last_attempt =
            (r_attempts == bgai_pkg::CNT_W'(bgai_pkg::BURST_LEN - 1));
        o_status.no_good      = (r_good == '0);
        o_status.div_done     = div_done;
        o_status.sum_last     =
            (bgai_pkg::FILL_W'(r_sidx) == (r_filled - 1'b1));
        o_status.map_direct   = map_direct;
        o_status.out_free     = out_free;
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_status  = r_out_status;
    assign o_burst_mean  = r_out_bmean;
    assign o_window_mean = r_out_wmean;
    assign o_charge_pct  = r_out_level;

endmodule

// File: src/bgai_ctrl.sv
// controller: sequences accumulation and the burst-end divisions
`timescale 1ns / 1ps

module bgai_ctrl (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  bgai_pkg::t_bgai_status    i_status,
    output bgai_pkg::t_bgai_cmd       o_cmd
);

    bgai_pkg::t_state r_state, n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bgai_pkg::S_ACCEPT;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.div_sel = bgai_pkg::DIV_BURST;
        case (r_state)
            bgai_pkg::S_ACCEPT: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.acc = 1'b1;
                    if (i_status.last_attempt) begin
                        n_state = bgai_pkg::S_CHECK;
                    end
                end
            end
            bgai_pkg::S_CHECK: begin
                if (i_status.no_good) begin
                    n_state = bgai_pkg::S_FAIL;
                end else begin
                    n_state = bgai_pkg::S_MEAN_GO;
                end
            end
            bgai_pkg::S_MEAN_GO: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = bgai_pkg::DIV_BURST;
                n_state         = bgai_pkg::S_MEAN_WAIT;
            end
            bgai_pkg::S_MEAN_WAIT: begin
                if (i_status.div_done) begin
                    o_cmd.latch_mean = 1'b1;
                    n_state          = bgai_pkg::S_SUM;
                end
            end
            bgai_pkg::S_SUM: begin
                o_cmd.sum_step = 1'b1;
                if (i_status.sum_last) begin
                    n_state = bgai_pkg::S_WIN_GO;
                end
            end
            bgai_pkg::S_WIN_GO: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = bgai_pkg::DIV_WINDOW;
                n_state         = bgai_pkg::S_WIN_WAIT;
            end
            bgai_pkg::S_WIN_WAIT: begin
                if (i_status.div_done) begin
                    o_cmd.latch_wmean = 1'b1;
                    n_state           = bgai_pkg::S_MAP;
                end
            end
            bgai_pkg::S_MAP: begin
                o_cmd.map_load = 1'b1;
                if (i_status.map_direct) begin
                    n_state = bgai_pkg::S_OUT;
                end else begin
                    n_state = bgai_pkg::S_PCT_GO;
                end
            end
            bgai_pkg::S_PCT_GO: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = bgai_pkg::DIV_PERCENT;
                n_state         = bgai_pkg::S_PCT_WAIT;
            end
            bgai_pkg::S_PCT_WAIT: begin
                if (i_status.div_done) begin
                    o_cmd.latch_pct = 1'b1;
                    n_state         = bgai_pkg::S_OUT;
                end
            end
            bgai_pkg::S_FAIL: begin
                if (i_status.out_free) begin
                    o_cmd.load_fail = 1'b1;
                    o_cmd.clr_burst = 1'b1;
                    n_state         = bgai_pkg::S_ACCEPT;
                end
            end
            bgai_pkg::S_OUT: begin
                if (i_status.out_free) begin
                    o_cmd.load_ok   = 1'b1;
                    o_cmd.clr_burst = 1'b1;
                    n_state         = bgai_pkg::S_ACCEPT;
                end
            end
            default: begin
                n_state = bgai_pkg::S_ACCEPT;
            end
        endcase
    end

endmodule

// File: src/bgai_checker.sv
// port-level checks of the battery gauge, bound to the top level
`timescale 1ns / 1ps

module bgai_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              o_in_ready,
    input  logic                              o_out_valid,
    input  logic                              i_out_ready,
    input  logic                              o_status,
    input  logic [bgai_pkg::SAMPLE_W-1:0]     o_burst_mean,
    input  logic [bgai_pkg::SAMPLE_W-1:0]     o_window_mean,
    input  logic [bgai_pkg::PCT_W-1:0]        o_charge_pct
);

    // a stalled result transaction holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_status)
            && $stable(o_burst_mean) && $stable(o_window_mean)
            && $stable(o_charge_pct))
        else $error("result payload changed while stalled");

    // a failed burst reports all-zero fields
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status |-> o_burst_mean == '0 && o_window_mean == '0
            && o_charge_pct == '0)
        else $error("failed burst with nonzero fields");

    // level stays within full scale
    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_charge_pct <= bgai_pkg::FULL_PERCENT)
        else $error("level above full scale");

    // reset leaves no result pending and input open
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("block not idle after reset");

endmodule

bind battery_gauge_average_interpolate bgai_checker u_bgai_checker (.*);

// File: tb/sv/testbench.sv
// self-checking testbench for the battery gauge burst average and percent mapping
`timescale 1ns / 1ps

module testbench;

    localparam int          MAX_SAMPLE    = (1 << bgai_pkg::SAMPLE_W) - 1;
    localparam int          SETTLE_CYCLES = 100;
    localparam int          HOLD_CYCLES   = 400;
    localparam longint      TIMEOUT_NS    = 3_000_000;

    localparam logic [bgai_pkg::CFG_IDX_W-1:0] POINT_REG [bgai_pkg::POINT_COUNT] = '{
        bgai_pkg::REG_POINT_ZERO, bgai_pkg::REG_POINT_TWENTY, bgai_pkg::REG_POINT_FORTY,
        bgai_pkg::REG_POINT_SIXTY, bgai_pkg::REG_POINT_EIGHTY, bgai_pkg::REG_POINT_FULL
    };

    // one gauge reading as it leaves the block
    typedef struct packed {
        logic                          status;
        logic [bgai_pkg::SAMPLE_W-1:0] burst_mean;
        logic [bgai_pkg::SAMPLE_W-1:0] window_mean;
        logic [bgai_pkg::PCT_W-1:0]    level;
    } t_gauge_reading;

    // shapes of a burst of converter attempts
    typedef enum int {
        BURST_STEADY,
        BURST_SCATTER,
        BURST_SPARSE,
        BURST_DEAD
    } t_burst_kind;

    // block ports
    logic                           i_clk           = 1'b0;
    logic                           i_rst_n         = 1'b0;
    logic                           i_cfg_wr_en     = 1'b0;
    logic [bgai_pkg::CFG_IDX_W-1:0] i_cfg_index     = bgai_pkg::REG_POINT_ZERO;
    logic [bgai_pkg::SAMPLE_W-1:0]  i_cfg_data      = '0;
    logic                           i_in_valid      = 1'b0;
    logic                           o_in_ready;
    logic [bgai_pkg::SAMPLE_W-1:0]  i_sample_value  = '0;
    logic                           i_sample_good   = 1'b0;
    logic                           o_out_valid;
    logic                           i_out_ready     = 1'b0;
    logic                           o_status;
    logic [bgai_pkg::SAMPLE_W-1:0]  o_burst_mean;
    logic [bgai_pkg::SAMPLE_W-1:0]  o_window_mean;
    logic [bgai_pkg::PCT_W-1:0]     o_charge_pct;

    // gauge predictor state
    logic [bgai_pkg::SAMPLE_W-1:0]  point_shadow [bgai_pkg::POINT_COUNT];
    logic [bgai_pkg::SAMPLE_W-1:0]  window_copy [bgai_pkg::WINDOW_DEPTH];
    int unsigned          burst_total;
    int unsigned          burst_good;
    int unsigned          burst_tries;
    int unsigned          window_wr;
    int unsigned          window_count;
    t_gauge_reading       gauge_pending [$];

    // traffic control and bookkeeping
    logic                 tx_gaps_on    = 1'b1;
    logic                 rx_stalls_on  = 1'b1;
    int unsigned          rx_hold_left  = 0;
    int unsigned          rx_stall_left = 0;
    int unsigned          mismatch_count = 0;
    int unsigned          burst_count   = 0;
    int unsigned          failed_count  = 0;
    int unsigned          setting_count = 0;
    t_gauge_reading       want;

    battery_gauge_average_interpolate dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_sample_value  (i_sample_value),
        .i_sample_good   (i_sample_good),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_status        (o_status),
        .o_burst_mean    (o_burst_mean),
        .o_window_mean   (o_window_mean),
        .o_charge_pct    (o_charge_pct)
    );

    // 100 MHz clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // piecewise-linear percent from the current breakpoints
    function automatic logic [bgai_pkg::PCT_W-1:0] level_from_reading(input int unsigned v);
        int unsigned lo;
        int unsigned hi;
        int unsigned step;
        step = 32'(bgai_pkg::STEP_PERCENT);
        if (v < point_shadow[0]) return '0;
        if (v >= point_shadow[bgai_pkg::POINT_COUNT-1]) return bgai_pkg::FULL_PERCENT;
        for (int k = 0; k < bgai_pkg::POINT_COUNT - 1; k++) begin
            lo = 32'(point_shadow[k]);
            hi = 32'(point_shadow[k+1]);
            if (v >= lo && v < hi) begin
                return bgai_pkg::PCT_W'(k * step + (step * (v - lo)) / (hi - lo));
            end
        end
        // no segment matched, breakpoints out of order
        return bgai_pkg::FULL_PERCENT;
    endfunction

    // update the gauge state for one accepted attempt, queue a reading at burst end
    task automatic predict_gauge(input logic [bgai_pkg::SAMPLE_W-1:0] value,
                                 input logic good);
        t_gauge_reading r;
        int unsigned    wsum;
        if (good) begin
            burst_total += 32'(value);
            burst_good++;
        end
        burst_tries++;
        if (burst_tries == bgai_pkg::BURST_LEN) begin
            r = '0;
            burst_count++;
            if (burst_good == 0) begin
                // failed burst leaves the window alone
                r.status = 1'b1;
                failed_count++;
            end else begin
                r.burst_mean = bgai_pkg::SAMPLE_W'(burst_total / burst_good);
                window_copy[window_wr] = r.burst_mean;
                window_wr = (window_wr + 1) % bgai_pkg::WINDOW_DEPTH;
                if (window_count < bgai_pkg::WINDOW_DEPTH) window_count++;
                wsum = 0;
                for (int i = 0; i < window_count; i++) wsum += 32'(window_copy[i]);
                r.window_mean = bgai_pkg::SAMPLE_W'(wsum / window_count);
                r.level = level_from_reading(32'(r.window_mean));
            end
            gauge_pending.push_back(r);
            burst_total = 0;
            burst_good  = 0;
            burst_tries = 0;
        end
    endtask

    // offer one attempt, optionally after a random gap, and wait for the transaction
    task automatic send_attempt(input logic [bgai_pkg::SAMPLE_W-1:0] value,
                                input logic good);
        int unsigned gap;
        @(negedge i_clk);
        if (tx_gaps_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 9);
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid     = 1'b1;
        i_sample_value = value;
        i_sample_good  = good;
        forever begin
            @(posedge i_clk);
            if (o_in_ready) break;
        end
        predict_gauge(value, good);
    endtask

    // stop offering and wait for every queued reading
    task automatic pause_until_drained();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (gauge_pending.size() != 0) @(posedge i_clk);
    endtask

    // drained plus enough cycles for any burst-end work still in flight
    task automatic wait_idle();
        pause_until_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_point(input int k, input logic [bgai_pkg::SAMPLE_W-1:0] value);
        @(negedge i_clk);
        i_cfg_wr_en = 1'b1;
        i_cfg_index = POINT_REG[k];
        i_cfg_data  = value;
        @(negedge i_clk);
        i_cfg_wr_en = 1'b0;
        point_shadow[k] = value;
    endtask

    task automatic load_points(input logic [bgai_pkg::SAMPLE_W-1:0] p0,
                               input logic [bgai_pkg::SAMPLE_W-1:0] p1,
                               input logic [bgai_pkg::SAMPLE_W-1:0] p2,
                               input logic [bgai_pkg::SAMPLE_W-1:0] p3,
                               input logic [bgai_pkg::SAMPLE_W-1:0] p4,
                               input logic [bgai_pkg::SAMPLE_W-1:0] p5);
        write_point(0, p0);
        write_point(1, p1);
        write_point(2, p2);
        write_point(3, p3);
        write_point(4, p4);
        write_point(5, p5);
        setting_count++;
    endtask

    // reading near a breakpoint most of the time, else extremes or anything
    function automatic logic [bgai_pkg::SAMPLE_W-1:0] pick_reading();
        int t;
        case ($urandom_range(0, 9))
            0:       t = 0;
            1:       t = MAX_SAMPLE;
            2, 3:    t = $urandom_range(0, MAX_SAMPLE);
            default: t = int'(point_shadow[$urandom_range(0, bgai_pkg::POINT_COUNT - 1)])
                         + int'($urandom_range(0, 4)) - 2;
        endcase
        if (t < 0) t = 0;
        if (t > MAX_SAMPLE) t = MAX_SAMPLE;
        return bgai_pkg::SAMPLE_W'(t);
    endfunction

    // one full burst; failed attempts carry noise
    task automatic run_burst(input t_burst_kind kind,
                             input logic [bgai_pkg::SAMPLE_W-1:0] target);
        int unsigned                   lucky;
        logic                          good;
        logic [bgai_pkg::SAMPLE_W-1:0] value;
        lucky = $urandom_range(0, bgai_pkg::BURST_LEN - 1);
        for (int n = 0; n < bgai_pkg::BURST_LEN; n++) begin
            case (kind)
                BURST_STEADY:  good = ($urandom_range(0, 7) != 0);
                BURST_SCATTER: good = ($urandom_range(0, 3) != 0);
                BURST_SPARSE:  good = (n == lucky);
                default:       good = 1'b0;
            endcase
            if (kind == BURST_SCATTER || !good) begin
                value = bgai_pkg::SAMPLE_W'($urandom_range(0, MAX_SAMPLE));
            end else begin
                value = target;
            end
            send_attempt(value, good);
        end
    endtask

    // runs of three bursts share a target so the window settles on it
    task automatic run_bursts(input int count);
        logic [bgai_pkg::SAMPLE_W-1:0] target;
        t_burst_kind                   kind;
        target = '0;
        for (int b = 0; b < count; b++) begin
            if (b % 3 == 0) target = pick_reading();
            case ($urandom_range(0, 9))
                6:       kind = BURST_SCATTER;
                7:       kind = BURST_SPARSE;
                8:       kind = BURST_DEAD;
                default: kind = BURST_STEADY;
            endcase
            run_burst(kind, target);
        end
    endtask

    // field extremes, a masked sample and a burst with no good sample at reset breakpoints
    task automatic test_directed_bursts();
        for (int n = 0; n < bgai_pkg::BURST_LEN; n++) begin
            send_attempt(bgai_pkg::SAMPLE_W'(MAX_SAMPLE), 1'b1);
        end
        for (int n = 0; n < bgai_pkg::BURST_LEN; n++) begin
            if (n % 2 == 0) send_attempt('0, 1'b1);
            else send_attempt(bgai_pkg::SAMPLE_W'(MAX_SAMPLE), 1'b0);
        end
        for (int n = 0; n < bgai_pkg::BURST_LEN; n++) begin
            send_attempt((n % 2 == 0) ? bgai_pkg::SAMPLE_W'(MAX_SAMPLE) : '0, 1'b0);
        end
        wait_idle();
    endtask

    // fixed settings: reset values, full span, tight, equal, reversed, out of order
    task automatic test_breakpoint_sets();
        load_points(bgai_pkg::POINT_RESET[0], bgai_pkg::POINT_RESET[1],
                    bgai_pkg::POINT_RESET[2], bgai_pkg::POINT_RESET[3],
                    bgai_pkg::POINT_RESET[4], bgai_pkg::POINT_RESET[5]);
        run_bursts(5);
        wait_idle();
        load_points(12'd0, 12'd819, 12'd1638, 12'd2457, 12'd3276, 12'd4095);
        run_bursts(5);
        wait_idle();
        load_points(12'd1000, 12'd1001, 12'd1002, 12'd1003, 12'd1004, 12'd1005);
        run_bursts(5);
        wait_idle();
        load_points(12'd2048, 12'd2048, 12'd2048, 12'd2048, 12'd2048, 12'd2048);
        run_bursts(5);
        wait_idle();
        load_points(12'd4095, 12'd3000, 12'd2000, 12'd1000, 12'd500, 12'd0);
        run_bursts(5);
        wait_idle();
        load_points(12'd100, 12'd3000, 12'd2000, 12'd3500, 12'd3500, 12'd4000);
        run_bursts(5);
        wait_idle();
        load_points(12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0);
        run_bursts(5);
        wait_idle();
        load_points(12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095);
        run_bursts(5);
        wait_idle();
    endtask

    // random breakpoints, mostly sorted, last one left as drawn
    task automatic test_random_breakpoints();
        logic [bgai_pkg::SAMPLE_W-1:0] pts [bgai_pkg::POINT_COUNT];
        logic [bgai_pkg::SAMPLE_W-1:0] swap;
        for (int s = 0; s < 5; s++) begin
            for (int k = 0; k < bgai_pkg::POINT_COUNT; k++) begin
                pts[k] = bgai_pkg::SAMPLE_W'($urandom_range(0, MAX_SAMPLE));
            end
            if (s != 4) begin
                for (int i = 0; i < bgai_pkg::POINT_COUNT - 1; i++) begin
                    for (int j = 0; j < bgai_pkg::POINT_COUNT - 1 - i; j++) begin
                        if (pts[j] > pts[j+1]) begin
                            swap     = pts[j];
                            pts[j]   = pts[j+1];
                            pts[j+1] = swap;
                        end
                    end
                end
            end
            load_points(pts[0], pts[1], pts[2], pts[3], pts[4], pts[5]);
            run_bursts(7);
            wait_idle();
        end
    endtask

    // receiver holds off while bursts keep coming, so the input backs up
    task automatic test_receiver_hold();
        tx_gaps_on   = 1'b0;
        rx_hold_left = HOLD_CYCLES;
        run_bursts(4);
        tx_gaps_on   = 1'b1;
        wait_idle();
    endtask

    // sender waits for each reading before the next burst
    task automatic test_sender_pause();
        for (int b = 0; b < 3; b++) begin
            run_bursts(1);
            pause_until_drained();
        end
        wait_idle();
    endtask

    // back-to-back traffic with no idling on either side
    task automatic test_steady_stream();
        tx_gaps_on   = 1'b0;
        rx_stalls_on = 1'b0;
        run_bursts(8);
        wait_idle();
    endtask

    // result side: random stall bursts plus a requested long hold
    always @(negedge i_clk) begin
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            i_out_ready = 1'b0;
        end else if (rx_stall_left > 0) begin
            rx_stall_left--;
            i_out_ready = 1'b0;
        end else if (rx_stalls_on && $urandom_range(0, 5) == 0) begin
            rx_stall_left = $urandom_range(0, 8);
            i_out_ready = 1'b0;
        end else begin
            i_out_ready = 1'b1;
        end
    end

    task automatic check_field(input string label, input logic [15:0] want_v,
                               input logic [15:0] got_v);
        if (got_v !== want_v) begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, label, want_v, got_v);
            mismatch_count++;
        end
    endtask

    // compare each result transaction with the oldest predicted reading
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (gauge_pending.size() == 0) begin
                $display("%0t: unexpected result, expected none actual status %0d mean %0d",
                         $time, o_status, o_burst_mean);
                mismatch_count++;
            end else begin
                want = gauge_pending.pop_front();
                check_field("status", 16'(want.status), 16'(o_status));
                check_field("burst_mean", 16'(want.burst_mean), 16'(o_burst_mean));
                check_field("window_mean", 16'(want.window_mean), 16'(o_window_mean));
                check_field("charge_pct", 16'(want.level), 16'(o_charge_pct));
            end
        end
    end

    // main sequence
    initial begin
        for (int k = 0; k < bgai_pkg::POINT_COUNT; k++) begin
            point_shadow[k] = bgai_pkg::POINT_RESET[k];
        end
        for (int k = 0; k < bgai_pkg::WINDOW_DEPTH; k++) window_copy[k] = '0;
        burst_total  = 0;
        burst_good   = 0;
        burst_tries  = 0;
        window_wr    = 0;
        window_count = 0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed_bursts();
        test_breakpoint_sets();
        test_random_breakpoints();
        test_receiver_hold();
        test_sender_pause();
        test_steady_stream();

        $display("ran %0d bursts, %0d with no good sample, across %0d breakpoint settings",
                 burst_count, failed_count, setting_count);
        $display("%0d field mismatches seen", mismatch_count);
        if (mismatch_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // watchdog
    initial begin
        #(TIMEOUT_NS);
        $display("timeout with %0d readings outstanding", gauge_pending.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule
